[rtl/pct_pkg.sv]
// shared types, constants and helpers for the collision pair tracker
`default_nettype none

package pct_pkg;

  // field widths
  localparam int KEY_W   = 64;
  localparam int POS_W   = 32;
  localparam int SIZE_W  = 16;
  localparam int SCALE_W = 8;
  localparam int SSIZE_W = SIZE_W + SCALE_W;
  localparam int SUM_W   = SSIZE_W + 1;

  // operation codes
  localparam logic OP_TEST  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // contact event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ENTER = 2'd1;
  localparam logic [1:0] EV_STAY  = 2'd2;
  localparam logic [1:0] EV_EXIT  = 2'd3;

  // size scale after reset
  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd70;

  typedef struct packed {
    logic                     operation;
    logic [KEY_W-1:0]         pair_key;
    logic                     left_is_circle;
    logic                     right_is_circle;
    logic signed [POS_W-1:0]  left_x;
    logic signed [POS_W-1:0]  left_y;
    logic signed [POS_W-1:0]  right_x;
    logic signed [POS_W-1:0]  right_y;
    logic [SIZE_W-1:0]        left_w;
    logic [SIZE_W-1:0]        left_h;
    logic [SIZE_W-1:0]        right_w;
    logic [SIZE_W-1:0]        right_h;
  } in_item_t;

  typedef struct packed {
    logic [1:0] contact_event;
    logic       table_full;
  } res_item_t;

  // commands from the sequencer to the pair table
  typedef struct packed {
    logic start;
    logic clear;
    logic write;
    logic touch;
  } tbl_cmd_t;

  // lookup status from the pair table
  typedef struct packed {
    logic done;
    logic full;
    logic touching;
  } tbl_res_t;

  // size times the integer scale, full 24-bit integer product kept
  function automatic logic [SSIZE_W-1:0] scale_size(logic [SIZE_W-1:0] w,
                                                    logic [SCALE_W-1:0] sc);
    return {{SCALE_W{1'b0}}, w} * {{SIZE_W{1'b0}}, sc};
  endfunction

endpackage

`default_nettype wire

[rtl/pct_if.sv]
// valid/ready channel interfaces for test items and results
`default_nettype none

interface pct_in_if;
  logic               valid;
  logic               ready;
  pct_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pct_out_if;
  logic               valid;
  logic               ready;
  pct_pkg::res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/pct_geom.sv]
// four-stage box and circle overlap test
`default_nettype none

module pct_geom (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire pct_pkg::in_item_t              item,
  input  wire logic [pct_pkg::SCALE_W-1:0]    scale,
  output logic                                hit,
  output logic                                done
);

  localparam int SW = pct_pkg::SSIZE_W;
  localparam int UW = pct_pkg::SUM_W;
  localparam int PW = pct_pkg::POS_W;
  localparam int QW = 2 * UW;

  logic [2:0]    stg_r;
  logic          done_r;
  logic          hit_r;

  // stage 1 registers: scaled sizes
  logic [SW-1:0] lw_r, lh_r, rw_r, rh_r;

  // stage 2 registers
  logic          box_r, both_box_r, both_circ_r, far_r;
  logic [UW-1:0] adx_r, ady_r, rad_r;

  // stage 3 registers
  logic [QW-1:0] dx2_r, dy2_r, s2_r;

  // stage 2 combinational terms
  logic signed [PW:0]   dpx, dpy;
  logic [PW:0]          apx, apy;
  logic [UW-1:0]        sw, sh;
  logic signed [PW+2:0] lcx, lcy, rcx, rcy, dcx, dcy;
  logic [PW+1:0]        acx, acy;
  logic                 box_hit, far;

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= '0;
      done_r <= 1'b0;
    end else begin
      stg_r <= {stg_r[1:0], start};
      if (start) begin
        done_r <= 1'b0;
      end else if (stg_r[2]) begin
        done_r <= 1'b1;
      end
    end
  end

  // stage 1: scale the sizes
  always_ff @(posedge clk) begin
    if (start) begin
      lw_r <= pct_pkg::scale_size(item.left_w, scale);
      lh_r <= pct_pkg::scale_size(item.left_h, scale);
      rw_r <= pct_pkg::scale_size(item.right_w, scale);
      rh_r <= pct_pkg::scale_size(item.right_h, scale);
    end
  end

  // stage 2: doubled gaps and size sums
  always_comb begin
    sw  = {1'b0, lw_r} + {1'b0, rw_r};
    sh  = {1'b0, lh_r} + {1'b0, rh_r};
    dpx = $signed({item.left_x[PW-1], item.left_x}) - $signed({item.right_x[PW-1], item.right_x});
    dpy = $signed({item.left_y[PW-1], item.left_y}) - $signed({item.right_y[PW-1], item.right_y});
    apx = dpx[PW] ? (PW+1)'(0) - dpx : dpx;
    apy = dpy[PW] ? (PW+1)'(0) - dpy : dpy;
    box_hit = ({apx, 1'b0} < {{(PW+2-UW){1'b0}}, sw})
           && ({apy, 1'b0} < {{(PW+2-UW){1'b0}}, sh});
    lcx = $signed({{2{item.left_x[PW-1]}}, item.left_x, 1'b0})
        + $signed({{(PW+3-SW){1'b0}}, lw_r});
    lcy = $signed({{2{item.left_y[PW-1]}}, item.left_y, 1'b0})
        + $signed({{(PW+3-SW){1'b0}}, lh_r});
    rcx = $signed({{2{item.right_x[PW-1]}}, item.right_x, 1'b0})
        + $signed({{(PW+3-SW){1'b0}}, rw_r});
    rcy = $signed({{2{item.right_y[PW-1]}}, item.right_y, 1'b0})
        + $signed({{(PW+3-SW){1'b0}}, rh_r});
    dcx = lcx - rcx;
    dcy = lcy - rcy;
    acx = dcx[PW+2] ? (PW+2)'(-dcx) : dcx[PW+1:0];
    acy = dcy[PW+2] ? (PW+2)'(-dcy) : dcy[PW+1:0];
    far = (acx > {{(PW+2-UW){1'b0}}, sw}) || (acy > {{(PW+2-UW){1'b0}}, sw});
  end

  always_ff @(posedge clk) begin
    if (stg_r[0]) begin
      box_r       <= box_hit;
      both_box_r  <= !item.left_is_circle && !item.right_is_circle;
      both_circ_r <= item.left_is_circle && item.right_is_circle;
      far_r       <= far;
      adx_r       <= acx[UW-1:0];
      ady_r       <= acy[UW-1:0];
      rad_r       <= sw;
    end
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    if (stg_r[1]) begin
      dx2_r <= {{UW{1'b0}}, adx_r} * {{UW{1'b0}}, adx_r};
      dy2_r <= {{UW{1'b0}}, ady_r} * {{UW{1'b0}}, ady_r};
      s2_r  <= {{UW{1'b0}}, rad_r} * {{UW{1'b0}}, rad_r};
    end
  end

  // stage 4: final decision by shape kinds
  always_ff @(posedge clk) begin
    if (stg_r[2]) begin
      if (both_box_r) begin
        hit_r <= box_r;
      end else if (both_circ_r) begin
        hit_r <= !far_r && (({1'b0, dx2_r} + {1'b0, dy2_r}) <= {1'b0, s2_r});
      end else begin
        hit_r <= 1'b0;
      end
    end
  end

  assign hit  = hit_r;
  assign done = done_r;

endmodule

`default_nettype wire

[rtl/pct_table.sv]
// pair table: key memory with fill count and a one-read-per-cycle key scan
`default_nettype none

module pct_table #(
  parameter int PAIR_SLOTS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pct_pkg::tbl_cmd_t           cmd,
  input  wire logic [pct_pkg::KEY_W-1:0]   key,
  output pct_pkg::tbl_res_t                res
);

  localparam int IW = $clog2(PAIR_SLOTS);
  localparam int CW = $clog2(PAIR_SLOTS + 1);
  localparam int KW = pct_pkg::KEY_W;

  // entry: touching mark over the pair key
  logic [KW:0]   mem [PAIR_SLOTS];

  logic [CW-1:0] count_r;
  logic [CW-1:0] addr_r;
  logic          scan_r;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic [KW:0]   rd_data_r;
  logic [IW-1:0] slot_r;
  logic          new_r;
  logic          full_r;
  logic          touch_r;
  logic          done_r;

  logic          match;
  logic          at_end;

  assign match  = rd_vld_r && (rd_data_r[KW-1:0] == key);
  assign at_end = (addr_r == count_r);

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[slot_r] <= {cmd.touch, key};
    end
    rd_data_r <= mem[addr_r[IW-1:0]];
    rd_idx_r  <= addr_r[IW-1:0];
  end

  // scan sequencing and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      addr_r   <= '0;
      scan_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.write && new_r) begin
        count_r <= count_r + CW'(1);
      end

      if (cmd.start) begin
        scan_r   <= 1'b1;
        addr_r   <= '0;
        rd_vld_r <= 1'b0;
        done_r   <= 1'b0;
      end else if (scan_r) begin
        if (match || at_end) begin
          scan_r   <= 1'b0;
          rd_vld_r <= 1'b0;
          done_r   <= 1'b1;
        end else begin
          rd_vld_r <= 1'b1;
          addr_r   <= addr_r + CW'(1);
        end
      end else begin
        rd_vld_r <= 1'b0;
      end
    end
  end

  // lookup outcome
  always_ff @(posedge clk) begin
    if (scan_r && !cmd.start) begin
      if (match) begin
        slot_r  <= rd_idx_r;
        touch_r <= rd_data_r[KW];
        new_r   <= 1'b0;
        full_r  <= 1'b0;
      end else if (at_end) begin
        slot_r  <= count_r[IW-1:0];
        touch_r <= 1'b0;
        full_r  <= (count_r == CW'(PAIR_SLOTS));
        new_r   <= (count_r != CW'(PAIR_SLOTS));
      end
    end
  end

  assign res.done     = done_r;
  assign res.full     = full_r;
  assign res.touching = touch_r;

endmodule

`default_nettype wire

[rtl/collision_pair_event_tracker.sv]
// collision pair tracker top level: sequencer, scale register, output register
//
//  channel   dir  handshake         payload
//  in_ch     in   valid/ready       operation, pair key, shape kinds, positions, sizes
//  out_ch    out  valid/ready       contact_event, table_full
//  cfg_*     in   cfg_we            cfg_wdata = size_scale
//
// a test transaction scans the stored pairs up to the match: the key memory gives
// one entry per cycle, and the overlap test runs alongside in four stages. a clear
// transaction goes straight to the output state without a scan.
// reset empties the table through its fill count, so no clearing pass is needed.
// a held result waits in the output register while the next transaction is taken.
`default_nettype none

module collision_pair_event_tracker #(
  parameter int PAIR_SLOTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pct_in_if.sink                             in_ch,
  pct_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [pct_pkg::SCALE_W-1:0]   cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                  state_r;
  logic [pct_pkg::SCALE_W-1:0] scale_r;
  pct_pkg::in_item_t           item_r;
  logic                        start_r;
  logic                        out_valid_r;
  pct_pkg::res_item_t          out_data_r;

  pct_pkg::tbl_cmd_t           tcmd;
  pct_pkg::tbl_res_t           tres;
  logic                        geo_hit;
  logic                        geo_done;
  logic                        accept;
  logic                        deliver;
  logic                        is_test;
  logic [1:0]                  ev;

  assign accept  = in_ch.valid && in_ch.ready;
  assign is_test = (item_r.operation == pct_pkg::OP_TEST);
  assign deliver = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= pct_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_ch.data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      start_r <= accept && (in_ch.data.operation == pct_pkg::OP_TEST);
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= (in_ch.data.operation == pct_pkg::OP_TEST) ? ST_WAIT : ST_OUT;
          end
        end
        ST_WAIT: begin
          if (!start_r && tres.done && geo_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (deliver) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // event from the old touching mark and the new overlap
  always_comb begin
    if (!is_test) begin
      ev = pct_pkg::EV_NONE;
    end else if (geo_hit) begin
      ev = tres.touching ? pct_pkg::EV_STAY : pct_pkg::EV_ENTER;
    end else begin
      ev = tres.touching ? pct_pkg::EV_EXIT : pct_pkg::EV_NONE;
    end
  end

  // table commands
  always_comb begin
    tcmd.start = start_r;
    tcmd.clear = deliver && !is_test;
    tcmd.write = deliver && is_test && !tres.full;
    tcmd.touch = geo_hit;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_data_r.contact_event <= ev;
      out_data_r.table_full    <= is_test && tres.full;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  pct_table #(
    .PAIR_SLOTS (PAIR_SLOTS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (tcmd),
    .key   (item_r.pair_key),
    .res   (tres)
  );

  pct_geom u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .item  (item_r),
    .scale (scale_r),
    .hit   (geo_hit),
    .done  (geo_done)
  );

endmodule

`default_nettype wire

[verif/contact_event_checker.sv]
// checker for the collision pair tracker: predicts every contact event and compares it
`default_nettype none

module contact_event_checker #(
  parameter int PAIR_SLOTS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [pct_pkg::SCALE_W-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire pct_pkg::in_item_t           in_data,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire pct_pkg::res_item_t          out_data,
  output int                               fail_count,
  output int                               pending_count,
  output int                               checked_count,
  output int                               full_count
);

  // predicted pair table and scale register
  logic [pct_pkg::KEY_W-1:0] slot_key      [PAIR_SLOTS];
  bit                        slot_used     [PAIR_SLOTS];
  bit                        slot_touching [PAIR_SLOTS];
  longint                    scale_now;

  // contact events still owed by the block, oldest first
  pct_pkg::res_item_t expected_events [$];

  int fails   = 0;
  int checked = 0;
  int fulls   = 0;

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // overlap test on doubled quantities, so every halving stays exact
  function automatic bit shapes_touch(pct_pkg::in_item_t it, longint sc);
    longint lx, ly, rx, ry, lw, lh, rw, rh, dx, dy, reach;
    lx = longint'($signed(it.left_x));
    ly = longint'($signed(it.left_y));
    rx = longint'($signed(it.right_x));
    ry = longint'($signed(it.right_y));
    lw = longint'(it.left_w) * sc;
    lh = longint'(it.left_h) * sc;
    rw = longint'(it.right_w) * sc;
    rh = longint'(it.right_h) * sc;
    if (!it.left_is_circle && !it.right_is_circle) begin
      return (mag(2 * (lx - rx)) < lw + rw) && (mag(2 * (ly - ry)) < lh + rh);
    end
    if (it.left_is_circle && it.right_is_circle) begin
      // centre offsets use width and height, the radius uses width only
      dx    = mag((2 * lx + lw) - (2 * rx + rw));
      dy    = mag((2 * ly + lh) - (2 * ry + rh));
      reach = lw + rw;
      if (dx > reach || dy > reach) begin
        return 1'b0;
      end
      return dx * dx + dy * dy <= reach * reach;
    end
    // box against circle never touches
    return 1'b0;
  endfunction

  // update the table for one transaction and queue the event it must give
  task automatic predict_contact(pct_pkg::in_item_t it);
    pct_pkg::res_item_t r;
    int                 hit_slot;
    int                 free_slot;
    bit                 was_touching;
    bit                 overlap_now;
    r = '0;
    if (it.operation == pct_pkg::OP_CLEAR) begin
      for (int i = 0; i < PAIR_SLOTS; i++) begin
        slot_used[i]     = 1'b0;
        slot_touching[i] = 1'b0;
      end
    end else begin
      hit_slot  = -1;
      free_slot = -1;
      for (int i = 0; i < PAIR_SLOTS; i++) begin
        if (slot_used[i]) begin
          if (hit_slot < 0 && slot_key[i] == it.pair_key) hit_slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      // new pair goes to the lowest free slot, or is flagged when none is left
      if (hit_slot < 0) begin
        if (free_slot >= 0) begin
          hit_slot                = free_slot;
          slot_used[hit_slot]     = 1'b1;
          slot_key[hit_slot]      = it.pair_key;
          slot_touching[hit_slot] = 1'b0;
        end else begin
          r.table_full = 1'b1;
        end
      end
      was_touching = (hit_slot >= 0) ? slot_touching[hit_slot] : 1'b0;
      overlap_now  = shapes_touch(it, scale_now);
      if (overlap_now) begin
        r.contact_event = was_touching ? pct_pkg::EV_STAY : pct_pkg::EV_ENTER;
        if (hit_slot >= 0) slot_touching[hit_slot] = 1'b1;
      end else if (was_touching) begin
        r.contact_event         = pct_pkg::EV_EXIT;
        slot_touching[hit_slot] = 1'b0;
      end else begin
        r.contact_event = pct_pkg::EV_NONE;
      end
    end
    expected_events.push_back(r);
  endtask

  // watch both channels and the register port at every edge
  always @(posedge clk) begin : watch
    pct_pkg::res_item_t want;
    if (!rst_n) begin
      scale_now = longint'(pct_pkg::SCALE_RESET);
      for (int i = 0; i < PAIR_SLOTS; i++) begin
        slot_used[i]     = 1'b0;
        slot_touching[i] = 1'b0;
      end
      expected_events.delete();
    end else begin
      if (cfg_we) scale_now = longint'(cfg_wdata);
      if (in_valid && in_ready) predict_contact(in_data);
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("result with nothing outstanding: contact_event %0d table_full %0d",
                 out_data.contact_event, out_data.table_full);
          fails++;
        end else begin
          want = expected_events.pop_front();
          checked++;
          if (out_data.table_full) fulls++;
          if (out_data.contact_event !== want.contact_event) begin
            $error("contact_event: expected %0d, actual %0d",
                   want.contact_event, out_data.contact_event);
            fails++;
          end
          if (out_data.table_full !== want.table_full) begin
            $error("table_full: expected %0d, actual %0d",
                   want.table_full, out_data.table_full);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    pending_count <= expected_events.size();
    checked_count <= checked;
    full_count    <= fulls;
  end

endmodule

`default_nettype wire

[verif/collision_pair_event_tracker_tb.sv]
// testbench top for the collision pair tracker: stimulus, flow control and verdict
`default_nettype none

module collision_pair_event_tracker_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int JAM_CYCLES     = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int POS_MIN        = 32'sh8000_0000;
  localparam int POS_MAX        = 32'sh7fff_ffff;
  localparam bit BOX            = 1'b0;
  localparam bit CIRCLE         = 1'b1;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [pct_pkg::SCALE_W-1:0] cfg_wdata;

  // flow control requests from the stimulus
  bit calm;
  bit jam_on;

  int                        cur_scale;
  int                        test_count     = 0;
  int                        clear_count    = 0;
  int                        scale_settings = 0;
  logic [pct_pkg::KEY_W-1:0] key_pool [128];

  int fail_count;
  int pending_count;
  int checked_count;
  int full_count;

  pct_in_if  in_ch  ();
  pct_out_if out_ch ();

  collision_pair_event_tracker #(
    .PAIR_SLOTS (64)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  contact_event_checker #(
    .PAIR_SLOTS (64)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .full_count    (full_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // every field but the operation random, used for noise and for clear transactions
  function automatic pct_pkg::in_item_t random_item();
    pct_pkg::in_item_t it;
    it.operation       = pct_pkg::OP_TEST;
    it.pair_key        = {$urandom, $urandom};
    it.left_is_circle  = 1'($urandom_range(0, 1));
    it.right_is_circle = 1'($urandom_range(0, 1));
    it.left_x          = $urandom;
    it.left_y          = $urandom;
    it.right_x         = $urandom;
    it.right_y         = $urandom;
    it.left_w          = (pct_pkg::SIZE_W)'($urandom_range(0, 65535));
    it.left_h          = (pct_pkg::SIZE_W)'($urandom_range(0, 65535));
    it.right_w         = (pct_pkg::SIZE_W)'($urandom_range(0, 65535));
    it.right_h         = (pct_pkg::SIZE_W)'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic pct_pkg::in_item_t clear_item();
    pct_pkg::in_item_t it;
    it           = random_item();
    it.operation = pct_pkg::OP_CLEAR;
    return it;
  endfunction

  function automatic pct_pkg::in_item_t shape_pair(logic [pct_pkg::KEY_W-1:0] key,
                                                   bit lc, bit rc,
                                                   int lx, int ly, int rx, int ry,
                                                   int lw, int lh, int rw, int rh);
    pct_pkg::in_item_t it;
    it.operation       = pct_pkg::OP_TEST;
    it.pair_key        = key;
    it.left_is_circle  = lc;
    it.right_is_circle = rc;
    it.left_x          = lx;
    it.left_y          = ly;
    it.right_x         = rx;
    it.right_y         = ry;
    it.left_w          = (pct_pkg::SIZE_W)'(lw);
    it.left_h          = (pct_pkg::SIZE_W)'(lh);
    it.right_w         = (pct_pkg::SIZE_W)'(rw);
    it.right_h         = (pct_pkg::SIZE_W)'(rh);
    return it;
  endfunction

  // mostly moderate sizes, now and then the full range
  function automatic int size_pick();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 2047);
  endfunction

  // a pair placed near its overlap boundary, so touching flips often
  function automatic pct_pkg::in_item_t paired_item(logic [pct_pkg::KEY_W-1:0] key);
    int kind, lw, lh, rw, rh, reach_x, reach_y, shift_x, shift_y;
    int lx, ly, rx, ry;
    bit both_circles;
    kind         = $urandom_range(0, 9);
    lw           = size_pick();
    lh           = size_pick();
    rw           = size_pick();
    rh           = size_pick();
    both_circles = (kind >= 4 && kind <= 7);
    reach_x      = (lw + rw) * cur_scale / 2 + 8;
    reach_y      = both_circles ? reach_x : (lh + rh) * cur_scale / 2 + 8;
    shift_x      = both_circles ? (lw - rw) * cur_scale / 2 : 0;
    shift_y      = both_circles ? (lh - rh) * cur_scale / 2 : 0;
    lx           = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
    ly           = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
    if ($urandom_range(0, 7) == 0) begin
      rx = lx;
      ry = ly;
    end else begin
      rx = lx + shift_x + int'($urandom_range(0, 2 * reach_x)) - reach_x;
      ry = ly + shift_y + int'($urandom_range(0, 2 * reach_y)) - reach_y;
    end
    return shape_pair(key, (kind >= 4 && kind <= 8), both_circles || kind == 9,
                      lx, ly, rx, ry, lw, lh, rw, rh);
  endfunction

  // offer one transaction, idling first at random, and wait for acceptance
  task automatic send(pct_pkg::in_item_t it);
    if (!calm) begin
      while ($urandom_range(0, 99) < 19) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    if (it.operation == pct_pkg::OP_CLEAR) clear_count++;
    else test_count++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait until every owed event has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic set_scale(int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= (pct_pkg::SCALE_W)'(value);
    cur_scale = value;
    scale_settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random phase: recurring keys from a pool, some noise and some clears
  task automatic run_phase(int n_items, int pool_size, int clear_permille);
    int                roll;
    pct_pkg::in_item_t it;
    for (int k = 0; k < pool_size; k++) key_pool[k] = {$urandom, $urandom};
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 999);
      if (roll < clear_permille) begin
        it = clear_item();
      end else if (roll < clear_permille + 80) begin
        it = random_item();
      end else begin
        it = paired_item(key_pool[$urandom_range(0, pool_size - 1)]);
      end
      send(it);
    end
    drain();
  endtask

  // result side: random back-pressure, one long hold when asked
  initial begin
    bit jam_seen;
    int hold_left;
    jam_seen     = 1'b0;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (jam_on && !jam_seen) begin
        jam_seen  = 1'b1;
        hold_left = JAM_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin
    logic [pct_pkg::KEY_W-1:0] ka, kb, kc;
    ka          = 64'h0000_0002_0000_0001;
    kb          = 64'h0000_0004_0000_0003;
    kc          = 64'h0000_0006_0000_0005;
    cur_scale   = int'(pct_pkg::SCALE_RESET);
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    calm        <= 1'b0;
    jam_on      <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset scale
    send(clear_item());
    // boxes: enter, stay, exit on the strict edge, enter just inside it
    send(shape_pair(ka, BOX, BOX, 0, 0, 100, 0, 256, 256, 256, 256));
    send(shape_pair(ka, BOX, BOX, 0, 0, 100, 0, 256, 256, 256, 256));
    send(shape_pair(ka, BOX, BOX, 0, 0, 17920, 0, 256, 256, 256, 256));
    send(shape_pair(ka, BOX, BOX, 0, 0, 17919, 0, 256, 256, 256, 256));
    // box against circle never touches, either way round
    send(shape_pair(ka, CIRCLE, BOX, 0, 0, 0, 0, 256, 256, 256, 256));
    send(shape_pair(ka, BOX, CIRCLE, 0, 0, 0, 0, 256, 256, 256, 256));
    // circles exactly one radius sum apart, then one step further
    send(shape_pair(kb, CIRCLE, CIRCLE, 17920, 0, 0, 0, 256, 256, 256, 256));
    send(shape_pair(kb, CIRCLE, CIRCLE, 17921, 0, 0, 0, 256, 256, 256, 256));
    // radius from width only while height moves the centre
    send(shape_pair(kc, CIRCLE, CIRCLE, 0, 0, 0, 0, 0, 512, 0, 0));
    send(shape_pair(kc, CIRCLE, CIRCLE, 0, 0, 0, 0, 0, 512, 0, 512));
    // extreme keys, positions and sizes
    send(shape_pair('1, BOX, BOX, POS_MIN, POS_MAX, POS_MAX, POS_MIN,
                    65535, 65535, 65535, 65535));
    send(shape_pair('0, CIRCLE, CIRCLE, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                    65535, 65535, 65535, 65535));
    send(shape_pair('0, BOX, BOX, POS_MIN, POS_MIN, POS_MIN, POS_MIN,
                    65535, 65535, 65535, 65535));
    send(shape_pair('0, BOX, BOX, 5, 5, 5, 5, 0, 0, 0, 0));
    // after a clear a known pair enters again
    send(clear_item());
    send(shape_pair(ka, BOX, BOX, 0, 0, 100, 0, 256, 256, 256, 256));
    drain();

    // random phases across scale settings
    set_scale(1);
    run_phase(250, 8, 30);
    set_scale(255);
    run_phase(250, 12, 30);
    set_scale(0);
    run_phase(100, 6, 30);
    // many keys and rare clears, so the pair table fills
    set_scale($urandom_range(1, 254));
    run_phase(300, 100, 2);
    // no idling on either side
    set_scale($urandom_range(1, 254));
    calm <= 1'b1;
    run_phase(250, 16, 30);
    calm <= 1'b0;
    // long receiver hold while items keep coming
    set_scale(int'(pct_pkg::SCALE_RESET));
    jam_on <= 1'b1;
    run_phase(250, 10, 30);
    set_scale($urandom_range(2, 254));
    run_phase(300, 20, 30);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d pair tests and %0d table clears under %0d scale settings",
             test_count, clear_count, scale_settings);
    $display("%0d contact events compared, %0d of them flagged with the pair table full",
             checked_count, full_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
